// ----- design/pfra_pkg.sv -----
`default_nettype none

package pfra_pkg;

  localparam int unsigned FRAME_W  = 13;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WIDE_W   = 17;

  localparam int unsigned DEF_TRACKED_FRAMES = 4096;
  localparam int unsigned BASE_FRAME         = 256;

  localparam logic [COUNT_W-1:0] USED_MARK = 8'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SHARE = 3'd2,
    CMD_INIT  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_LOW       = 3'd1,
    STS_OOM       = 3'd2,
    STS_NONEXIST  = 3'd3,
    STS_FREE_FREE = 3'd4,
    STS_SATURATED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_RMW,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [FRAME_W-1:0]  result_frame;
    logic [COUNT_W-1:0]  ref_count;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  free_frames;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/pfra_mem.sv -----
`default_nettype none

module pfra_mem #(
  parameter int unsigned DEPTH = pfra_pkg::DEF_TRACKED_FRAMES,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [pfra_pkg::COUNT_W-1:0] wdata_i,
  input  wire logic                         re_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [pfra_pkg::COUNT_W-1:0] rdata_o
);
  import pfra_pkg::*;

  logic [COUNT_W-1:0] mem_q [DEPTH];
  logic [COUNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/pfra_seq.sv -----
`default_nettype none

module pfra_seq #(
  parameter int unsigned TRACKED_FRAMES = pfra_pkg::DEF_TRACKED_FRAMES,
  localparam int unsigned AW = $clog2(TRACKED_FRAMES)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pfra_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [pfra_pkg::FRAME_W-1:0]  frame_i,
  input  wire logic [pfra_pkg::FRAME_W-1:0]  end_frame_i,
  output logic                               rsp_valid_o,
  output pfra_pkg::rsp_t                     rsp_o,
  input  wire logic                          out_free_i,
  output logic                               mem_we_o,
  output logic      [AW-1:0]                 mem_waddr_o,
  output logic      [pfra_pkg::COUNT_W-1:0]  mem_wdata_o,
  output logic                               mem_re_o,
  output logic      [AW-1:0]                 mem_raddr_o,
  input  wire logic [pfra_pkg::COUNT_W-1:0]  mem_rdata_i
);
  import pfra_pkg::*;

  localparam int unsigned ZW    = $clog2(TRACKED_FRAMES + 1);
  localparam int unsigned TRK_W = WIDE_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TRACKED_FRAMES - 1);

  state_e               state_q, state_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [FRAME_W-1:0]   start_q, start_d;
  logic [FRAME_W-1:0]   end_q, end_d;
  logic [FRAME_W-1:0]   top_q, top_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [STATUS_W-1:0]  pre_st_q, pre_st_d;
  logic                 sweep_rsp_q, sweep_rsp_d;
  logic [ZW-1:0]        zero_cnt_q, zero_cnt_d;
  logic [FRAME_W-1:0]   res_frame_q, res_frame_d;
  logic [COUNT_W-1:0]   res_count_q, res_count_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;

  logic                 accept;
  logic [WIDE_W-1:0]    in_wide;
  logic [WIDE_W-1:0]    in_diff;
  logic                 in_low;
  logic                 in_tracked;
  logic [WIDE_W-1:0]    entry_frame;
  logic                 in_range;
  logic                 rd_zero;
  logic                 last_idx;
  logic [ZW+FRAME_W-1:0] zc_ext;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_wide     = WIDE_W'(frame_i);
  assign in_low      = in_wide < WIDE_W'(BASE_FRAME);
  assign in_diff     = in_wide - WIDE_W'(BASE_FRAME);
  assign in_tracked  = !in_low && ({1'b0, in_diff} < TRK_W'(TRACKED_FRAMES));
  assign entry_frame = WIDE_W'(BASE_FRAME) + WIDE_W'(idx_q);
  assign in_range    = (entry_frame >= WIDE_W'(start_q)) && (entry_frame < WIDE_W'(end_q));
  assign rd_zero     = (mem_rdata_i == '0);
  assign last_idx    = (idx_q == LAST_IDX);
  assign zc_ext      = (ZW + FRAME_W)'(zero_cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_ALLOC: state_d = (zero_cnt_q == '0) ? S_RESP : S_SCAN;
            CMD_FREE,
            CMD_SHARE,
            CMD_QUERY: state_d = S_RMW;
            CMD_INIT:  state_d = S_SWEEP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_SWEEP: begin
        if (last_idx) begin
          state_d = sweep_rsp_q ? S_RESP : S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_zero) begin
          state_d = S_RESP;
        end
      end
      S_RMW:   state_d = S_RESP;
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d        = cmd_q;
    start_d      = start_q;
    end_d        = end_q;
    top_d        = top_q;
    idx_d        = idx_q;
    pre_st_d     = pre_st_q;
    sweep_rsp_d  = sweep_rsp_q;
    zero_cnt_d   = zero_cnt_q;
    res_frame_d  = res_frame_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = idx_q;
    rsp_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_i;
          start_d      = frame_i;
          end_d        = end_frame_i;
          res_frame_d  = '0;
          res_count_d  = '0;
          res_status_d = STS_OK;
          if (in_low) begin
            pre_st_d = STS_LOW;
          end else if (!in_tracked) begin
            pre_st_d = STS_NONEXIST;
          end else if (cmd_i != CMD_QUERY && frame_i >= top_q) begin
            pre_st_d = STS_NONEXIST;
          end else begin
            pre_st_d = STS_OK;
          end
          case (cmd_i)
            CMD_ALLOC: begin
              if (zero_cnt_q == '0) begin
                res_status_d = STS_OOM;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = LAST_IDX;
                idx_d       = LAST_IDX;
              end
            end
            CMD_FREE,
            CMD_SHARE,
            CMD_QUERY: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = in_diff[AW-1:0];
              idx_d       = in_diff[AW-1:0];
            end
            CMD_INIT: begin
              top_d       = end_frame_i;
              zero_cnt_d  = '0;
              idx_d       = '0;
              sweep_rsp_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = in_range ? '0 : USED_MARK;
        if (in_range) begin
          zero_cnt_d = zero_cnt_q + ZW'(1);
        end
        idx_d = idx_q + AW'(1);
        if (last_idx) begin
          sweep_rsp_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_zero) begin
          mem_we_o     = 1'b1;
          mem_wdata_o  = COUNT_W'(1);
          zero_cnt_d   = zero_cnt_q - ZW'(1);
          res_frame_d  = entry_frame[FRAME_W-1:0];
          res_count_d  = COUNT_W'(1);
          res_status_d = STS_OK;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end
      S_RMW: begin
        if (pre_st_q != STS_OK) begin
          res_status_d = pre_st_q;
        end else begin
          case (cmd_q)
            CMD_FREE: begin
              if (rd_zero) begin
                res_status_d = STS_FREE_FREE;
              end else begin
                mem_we_o    = 1'b1;
                mem_wdata_o = mem_rdata_i - COUNT_W'(1);
                res_count_d = mem_rdata_i - COUNT_W'(1);
                if (mem_rdata_i == COUNT_W'(1)) begin
                  zero_cnt_d = zero_cnt_q + ZW'(1);
                end
              end
            end
            CMD_SHARE: begin
              if (mem_rdata_i == COUNT_MAX) begin
                res_status_d = STS_SATURATED;
                res_count_d  = COUNT_MAX;
              end else begin
                mem_we_o    = 1'b1;
                mem_wdata_o = mem_rdata_i + COUNT_W'(1);
                res_count_d = mem_rdata_i + COUNT_W'(1);
                if (rd_zero) begin
                  zero_cnt_d = zero_cnt_q - ZW'(1);
                end
              end
            end
            CMD_QUERY: res_count_d = mem_rdata_i;
            default: ;
          endcase
        end
      end
      S_RESP: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign rsp_o.result_frame = res_frame_q;
  assign rsp_o.ref_count    = res_count_q;
  assign rsp_o.status       = res_status_q;
  assign rsp_o.free_frames  = zc_ext[FRAME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      idx_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      top_q       <= FRAME_W'(BASE_FRAME);
      sweep_rsp_q <= 1'b0;
      zero_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      start_q     <= start_d;
      end_q       <= end_d;
      top_q       <= top_d;
      sweep_rsp_q <= sweep_rsp_d;
      zero_cnt_q  <= zero_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pre_st_q     <= pre_st_d;
    res_frame_q  <= res_frame_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
  end

  a_scan_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> zero_cnt_q != '0)
    else $error("scan running with no free entry");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("read and write issued together");

  a_rmw_write_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW && mem_we_o) |-> pre_st_q == STS_OK)
    else $error("count written for a rejected frame");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_cnt_q <= ZW'(TRACKED_FRAMES))
    else $error("free count beyond tracked entries");

  a_resp_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free_i) |=> state_q == S_IDLE)
    else $error("result not handed to output stage");

endmodule

`default_nettype wire

// ----- design/page_frame_refcount_allocator.sv -----
// Free, share and query go through S_RMW and S_RESP into the output register;
// unused commands go straight to S_RESP. Alloc passes over used entries on the way down from the
// top, one read at a time through the single read port of the count memory; out of memory answers
// from the free counter without a scan. Init: one memory write per entry. One item at a time.
// Reset: a sweep writes the used mark into every entry with the input stalled; top frame resets
// to the base frame and the free count to zero.
`default_nettype none

module page_frame_refcount_allocator #(
  parameter int unsigned TRACKED_FRAMES = pfra_pkg::DEF_TRACKED_FRAMES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pfra_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [pfra_pkg::FRAME_W-1:0]  frame_i,
  input  wire logic [pfra_pkg::FRAME_W-1:0]  end_frame_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [pfra_pkg::FRAME_W-1:0]  result_frame_o,
  output logic      [pfra_pkg::COUNT_W-1:0]  ref_count_o,
  output logic      [pfra_pkg::STATUS_W-1:0] status_o,
  output logic      [pfra_pkg::FRAME_W-1:0]  free_frames_o
);
  import pfra_pkg::*;

  localparam int unsigned AW = $clog2(TRACKED_FRAMES);

  logic               rsp_valid;
  rsp_t               rsp;
  logic               out_free;
  logic               load;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [COUNT_W-1:0] mem_rdata;

  pfra_seq #(
    .TRACKED_FRAMES(TRACKED_FRAMES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .frame_i     (frame_i),
    .end_frame_i (end_frame_i),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .out_free_i  (out_free),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pfra_mem #(
    .DEPTH(TRACKED_FRAMES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign load        = rsp_valid && out_free;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_frame_o = out_q.result_frame;
  assign ref_count_o    = out_q.ref_count;
  assign status_o       = out_q.status;
  assign free_frames_o  = out_q.free_frames;

endmodule

`default_nettype wire
